// File: design/permutation_smallest_cycle_arcs_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation cycle block
// Define ASSERT_OFF to compile every check to nothing.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_SMALLEST_CYCLE_ARCS_TOP_ASSERT_SVH
`define PERMUTATION_SMALLEST_CYCLE_ARCS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PSCA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSCA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`PSCA_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define PSCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSCA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: design/psca_pkg.sv
// ----------------------------------------------------------------------------
// psca_pkg
// Shared types and constants of the permutation cycle block.
// ----------------------------------------------------------------------------
package psca_pkg;

	localparam int SUCC_W      = 5;
	localparam int CNT_W       = 6;
	localparam int TOTAL_W     = 6;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int MIN_CITIES  = 2;
	localparam logic [CNT_W-1:0] CITY_COUNT_RST = 6'd32;

	// arc queue between scanner and output stage
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	typedef struct packed {
		logic [SUCC_W-1:0]  from_city;
		logic [SUCC_W-1:0]  to_city;
		logic               feasible;
		logic [TOTAL_W-1:0] cycle_total;
		logic               last_arc;
	} arc_t;

endpackage

// File: design/psca_ram.sv
// ----------------------------------------------------------------------------
// psca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psca_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/psca_front.sv
// ----------------------------------------------------------------------------
// psca_front
// Loads successor rows, walks the cycles, traces the shortest one into the
// arc queue, or queues one feasible record when there is a single tour.
// ----------------------------------------------------------------------------
`include "permutation_smallest_cycle_arcs_top_assert.svh"

module psca_front
	import psca_pkg::*;
#(
	parameter int MAX_CITIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  city_count,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SUCC_W-1:0] successor,
	output logic              push,
	output arc_t              push_rec,
	input  logic              full
);
	localparam int ADDR_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int ROW_W  = $clog2(MAX_CITIES + 1);
	localparam int V_W    = (ADDR_W > SUCC_W) ? ADDR_W : SUCC_W;
	localparam int KW0    = (ROW_W > V_W) ? ROW_W : V_W;
	localparam int KW     = ((KW0 > CNT_W) ? KW0 : CNT_W) + 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_WALK,
		ST_WAIT,
		ST_FEAS,
		ST_TR_RD,
		ST_TR_WT
	} state_t;

	state_t              state_q;
	logic [ROW_W-1:0]    rows_q;
	logic [ROW_W-1:0]    s_q;
	logic [V_W-1:0]      v_q;
	logic [ROW_W-1:0]    len_q;
	logic [ROW_W-1:0]    k_q;
	logic [ROW_W-1:0]    cycles_q;
	logic [ADDR_W-1:0]   best_start_q;
	logic [CNT_W-1:0]    best_len_q;
	logic [MAX_CITIES-1:0] seen_q;

	logic [KW-1:0]       cnt_ext;
	logic [KW-1:0]       n;
	logic [ADDR_W-1:0]   seen_idx;
	logic                seen_bit;
	logic                walk_go;
	logic                scan_done;
	logic                tr_last;
	logic                accept;
	logic                ram_re;
	logic [SUCC_W-1:0]   rdata;
	logic [TOTAL_W-1:0]  total;

	// clamp the city count into the supported range
	always_comb begin
		cnt_ext = KW'(city_count);
		if (cnt_ext < KW'(MIN_CITIES)) begin
			n = KW'(MIN_CITIES);
		end else if (cnt_ext > KW'(MAX_CITIES)) begin
			n = KW'(MAX_CITIES);
		end else begin
			n = cnt_ext;
		end
	end

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_LOAD);
	assign seen_idx  = (state_q == ST_SCAN) ? s_q[ADDR_W-1:0] : v_q[ADDR_W-1:0];
	assign seen_bit  = seen_q[seen_idx];
	assign walk_go   = (KW'(v_q) < n) && !seen_bit;
	assign scan_done = (KW'(s_q) == n);
	assign tr_last   = ((KW'(k_q) + KW'(1)) == KW'(best_len_q));
	assign ram_re    = ((state_q == ST_WALK) && walk_go) || (state_q == ST_TR_RD);
	assign total     = TOTAL_W'(cycles_q);

	psca_ram #(
		.WIDTH (SUCC_W),
		.DEPTH (MAX_CITIES)
	) u_next_table (
		.clk   (clk),
		.we    (accept),
		.waddr (rows_q[ADDR_W-1:0]),
		.wdata (successor),
		.re    (ram_re),
		.raddr (v_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		push     = 1'b0;
		push_rec = '0;
		case (state_q)
			ST_FEAS: begin
				push                 = !full;
				push_rec.feasible    = 1'b1;
				push_rec.cycle_total = total;
				push_rec.last_arc    = 1'b1;
			end
			ST_TR_WT: begin
				push                 = !full;
				push_rec.from_city   = SUCC_W'(v_q);
				push_rec.to_city     = rdata;
				push_rec.cycle_total = total;
				push_rec.last_arc    = tr_last;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			rows_q       <= '0;
			s_q          <= '0;
			v_q          <= '0;
			len_q        <= '0;
			k_q          <= '0;
			cycles_q     <= '0;
			best_start_q <= '0;
			best_len_q   <= '1;
			seen_q       <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						rows_q <= rows_q + ROW_W'(1);
						if ((KW'(rows_q) + KW'(1)) >= n) begin
							state_q  <= ST_SCAN;
							s_q      <= '0;
							cycles_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						v_q <= V_W'(best_start_q);
						k_q <= '0;
						if (KW'(cycles_q) < KW'(2)) begin
							state_q <= ST_FEAS;
						end else begin
							state_q <= ST_TR_RD;
						end
					end else if (seen_bit) begin
						s_q <= s_q + ROW_W'(1);
					end else begin
						cycles_q <= cycles_q + ROW_W'(1);
						v_q      <= V_W'(s_q[ADDR_W-1:0]);
						len_q    <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_go) begin
						seen_q[v_q[ADDR_W-1:0]] <= 1'b1;
						state_q <= ST_WAIT;
					end else begin
						// strict compare: the first of equal cycles wins
						if (KW'(len_q) < KW'(best_len_q)) begin
							best_len_q   <= CNT_W'(len_q);
							best_start_q <= s_q[ADDR_W-1:0];
						end
						s_q     <= s_q + ROW_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_WAIT: begin
					v_q     <= V_W'(rdata);
					len_q   <= len_q + ROW_W'(1);
					state_q <= ST_WALK;
				end
				ST_FEAS: begin
					if (!full) begin
						seen_q       <= '0;
						rows_q       <= '0;
						best_start_q <= '0;
						best_len_q   <= '1;
						state_q      <= ST_LOAD;
					end
				end
				ST_TR_RD: begin
					state_q <= ST_TR_WT;
				end
				ST_TR_WT: begin
					if (!full) begin
						v_q <= V_W'(rdata);
						k_q <= k_q + ROW_W'(1);
						if (tr_last) begin
							seen_q       <= '0;
							rows_q       <= '0;
							best_start_q <= '0;
							best_len_q   <= '1;
							state_q      <= ST_LOAD;
						end else begin
							state_q <= ST_TR_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`PSCA_ASSERT(a_wait_follows_walk, clk, arst_n, (state_q == ST_WAIT) |-> $past(state_q == ST_WALK), "table read wait entered without a walk step")
	`PSCA_ASSERT(a_last_ends_run, clk, arst_n, (push && push_rec.last_arc) |=> (state_q == ST_LOAD), "run did not return to loading after its last arc")
	`PSCA_ASSERT(a_cycles_bounded, clk, arst_n, (state_q != ST_LOAD) |-> (KW'(cycles_q) <= n), "more cycles counted than cities")

endmodule

// File: design/psca_fifo.sv
// ----------------------------------------------------------------------------
// psca_fifo
// Short arc queue between the cycle scanner and the output stage.
// ----------------------------------------------------------------------------
`include "permutation_smallest_cycle_arcs_top_assert.svh"

module psca_fifo
	import psca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  arc_t push_rec,
	output logic full,
	input  logic pop,
	output arc_t pop_rec,
	output logic empty
);
	arc_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full    = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Q_PTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Q_PTR_W + 1)'(1);
			end
		end
	end

	`PSCA_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "arc pushed into a full queue")
	`PSCA_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "arc popped from an empty queue")
	`PSCA_ASSERT(a_cnt_in_range, clk, arst_n, cnt_q <= (Q_PTR_W + 1)'(Q_DEPTH), "queue fill count out of range")

endmodule

// File: design/psca_back.sv
// ----------------------------------------------------------------------------
// psca_back
// Output register: pops arcs from the queue and holds them on the stream.
// ----------------------------------------------------------------------------
module psca_back
	import psca_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  arc_t                   pop_rec,
	input  logic                   empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);
	logic valid_q;
	arc_t rec_q;

	assign pop = !empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_rec;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {rec_q.cycle_total, rec_q.to_city, rec_q.from_city};
	assign m_tuser  = rec_q.feasible;
	assign m_tlast  = rec_q.last_arc;

endmodule

// File: design/permutation_smallest_cycle_arcs_top.sv
// ----------------------------------------------------------------------------
// permutation_smallest_cycle_arcs_top
// Splits an assignment permutation into cycles and streams the shortest one.
// ----------------------------------------------------------------------------
//   Slave stream: one transfer per row, in row order, s_tdata carrying the
//   successor city; after city_count rows (clamped to 2..MAX_CITIES) the block
//   walks every cycle from each unvisited city in order.
//   Master stream: one transfer marked feasible (m_tuser) for a single tour,
//   else the arcs of the shortest cycle in walk order, the first found winning
//   ties; m_tlast marks the final transfer of the run.
//   Timing: one row per cycle while loading; the walk scans each city, reads
//   the table and takes its registered data for each city visited, and closes
//   each cycle with a length compare; tracing reads the table, then queues
//   each arc, holding while the queue is full, all through the single read port.
//   s_tready stays low from the last row until the last arc is queued; a
//   four-entry arc queue and an output register absorb receiver stalls.
//   Reset clears the run state and sets city_count to 32; table contents are
//   unknown until loaded. The user must have cfg_we write city_count only
//   while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module permutation_smallest_cycle_arcs_top
	import psca_pkg::*;
#(
	parameter int MAX_CITIES = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CNT_W-1:0]       cfg_wdata,   // city_count
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,     // [4:0] successor, [7:5] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,     // [4:0] from_city, [9:5] to_city,
	                                            // [15:10] cycle_total
	output logic                   m_tuser,     // [0] feasible
	output logic                   m_tlast      // last_arc
);
	logic [CNT_W-1:0] city_count_q;
	logic             push;
	arc_t             push_rec;
	logic             full;
	logic             pop;
	arc_t             pop_rec;
	logic             empty;

	// hold the city count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CITY_COUNT_RST;
		end else if (cfg_we) begin
			city_count_q <= cfg_wdata;
		end
	end

	// front: load rows, walk cycles, trace the shortest one
	psca_front #(
		.MAX_CITIES (MAX_CITIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.city_count (city_count_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.successor  (s_tdata[SUCC_W-1:0]),
		.push       (push),
		.push_rec   (push_rec),
		.full       (full)
	);

	// queue: decouple tracing from the receiver
	psca_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	// back: drive the master stream from the output register
	psca_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_rec  (pop_rec),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
